FILE: rtl/cssm_pkg.sv
// Shared constants, types and a helper function of the caseless match scanner.
package cssm_pkg;

   localparam int MAX_PATTERN = 16;
   localparam int COLUMN_BITS = 16;
   localparam int LINE_BITS   = 16;
   localparam int OUT_BITS    = 16;
   localparam int LEN_BITS    = $clog2(MAX_PATTERN + 1);
   localparam int PIDX_BITS   = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
   localparam int REG_BITS    = 64;
   localparam int LEN_REG_BITS = 5;
   localparam int CSR_IDX_BITS = 2;
   localparam int KIND_BITS   = 2;

   // item kinds
   localparam logic [KIND_BITS-1:0] KIND_TEXT = 2'd0;
   localparam logic [KIND_BITS-1:0] KIND_EOL  = 2'd1;
   localparam logic [KIND_BITS-1:0] KIND_SOT  = 2'd2;

   // register indexes
   localparam logic [CSR_IDX_BITS-1:0] REG_PAT_LOW  = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] REG_PAT_HIGH = 2'd1;
   localparam logic [CSR_IDX_BITS-1:0] REG_PAT_LEN  = 2'd2;

   typedef struct packed {
      logic shift;
      logic clear;
   } cell_ctl_type;

   typedef struct packed {
      logic       active;
      logic [7:0] value;
   } pat_slot_type;

   function automatic logic [7:0] fold(input logic [7:0] b);
      logic [7:0] r;
      r = b;
      if ((b >= 8'h41) && (b <= 8'h5A)) begin
         r = b + 8'h20;
      end
      return r;
   endfunction

endpackage

FILE: rtl/cssm_ifs.sv
// Valid/ready channel interfaces for requests, responses and register writes.
interface cssm_req_if;
   logic                           valid;
   logic                           ready;
   logic [cssm_pkg::KIND_BITS-1:0] kind;
   logic [7:0]                     text_byte;
   modport source (output valid, output kind, output text_byte, input ready);
   modport sink (input valid, input kind, input text_byte, output ready);
endinterface

interface cssm_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [cssm_pkg::OUT_BITS-1:0] match_line;
   logic [cssm_pkg::OUT_BITS-1:0] match_start_col;
   logic [cssm_pkg::OUT_BITS-1:0] match_end_col;
   modport source (output valid, output match_line, output match_start_col,
                   output match_end_col, input ready);
   modport sink (input valid, input match_line, input match_start_col,
                 input match_end_col, output ready);
endinterface

interface cssm_csr_if;
   logic                              valid;
   logic                              ready;
   logic [cssm_pkg::CSR_IDX_BITS-1:0] index;
   logic [cssm_pkg::REG_BITS-1:0]     data;
   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

FILE: rtl/cssm_cell.sv
// One window cell: holds a folded text byte, passes it on, compares it.
module cssm_cell (
   input  logic                   clock,
   input  logic                   reset,
   input  cssm_pkg::cell_ctl_type ctl,
   input  logic [7:0]             byte_in,
   input  cssm_pkg::pat_slot_type pat,
   output logic [7:0]             byte_out,
   output logic                   ok
);
   logic [7:0] held_ff;
   logic [7:0] held_in;

   always_comb begin
      held_in = held_ff;
      if (ctl.clear) begin
         held_in = 8'h00;
      end else if (ctl.shift) begin
         held_in = byte_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff <= 8'h00;
      end else begin
         held_ff <= held_in;
      end
   end

   assign byte_out = held_ff;
   // inactive slots lie beyond the pattern and always agree
   assign ok = !pat.active || (held_ff == pat.value);
endmodule

FILE: rtl/caseless_substring_match_scanner.sv
// Top level: caseless substring scanner built on a shifting row of compare cells.
// Path: an accepted text item loads the compare stage; a hit then moves into the output register.
// Throughput: one item per cycle; a stalled response holds the compare stage and the
// window cells; ready drops only while the compare stage is full and the output item waits.
// Reset: synchronous, active high; clears pattern registers, window, line and column
// counters and all valid flags.
module caseless_substring_match_scanner (
   input logic          clock,
   input logic          reset,
   cssm_req_if.sink     req_if,
   cssm_rsp_if.source   rsp_if,
   cssm_csr_if.sink     csr_if
);
   localparam int NC = cssm_pkg::MAX_PATTERN;
   localparam int CB = cssm_pkg::COLUMN_BITS;
   localparam int LB = cssm_pkg::LINE_BITS;
   localparam int OB = cssm_pkg::OUT_BITS;
   localparam int LN = cssm_pkg::LEN_BITS;
   localparam int PI = cssm_pkg::PIDX_BITS;

   localparam logic [CB-1:0] COL_MAX  = {CB{1'b1}};
   localparam logic [LB-1:0] LINE_MAX = {LB{1'b1}};

   // ---------------- configuration registers ----------------
   logic [cssm_pkg::REG_BITS-1:0]     pat_low_ff,  pat_low_in;
   logic [cssm_pkg::REG_BITS-1:0]     pat_high_ff, pat_high_in;
   logic [cssm_pkg::LEN_REG_BITS-1:0] pat_len_ff,  pat_len_in;

   assign csr_if.ready = 1'b1;

   always_comb begin
      pat_low_in  = pat_low_ff;
      pat_high_in = pat_high_ff;
      pat_len_in  = pat_len_ff;
      if (csr_if.valid) begin
         unique case (csr_if.index)
            cssm_pkg::REG_PAT_LOW:  pat_low_in  = csr_if.data;
            cssm_pkg::REG_PAT_HIGH: pat_high_in = csr_if.data;
            cssm_pkg::REG_PAT_LEN:
               pat_len_in = csr_if.data[cssm_pkg::LEN_REG_BITS-1:0];
            default: ; // no register at this index
         endcase
      end
   end

   // Effective length, clamped to the window depth.
   logic [LN-1:0] len_eff;
   always_comb begin
      if (32'(pat_len_ff) > NC) begin
         len_eff = LN'(NC);
      end else begin
         len_eff = LN'(pat_len_ff);
      end
   end

   // Pattern as one byte vector; byte i at bits 8i+7:8i.
   logic [2*cssm_pkg::REG_BITS-1:0] pat_all;
   assign pat_all = {pat_high_ff, pat_low_ff};

   // ---------------- handshake and decode ----------------
   logic s1_valid_ff, s1_valid_in;
   logic s1_armed_ff, s1_armed_in;
   logic [CB-1:0] s1_col_ff, s1_col_in;
   logic [LB-1:0] s1_line_ff, s1_line_in;

   logic rsp_valid_ff, rsp_valid_in;
   logic [OB-1:0] rsp_line_ff, rsp_line_in;
   logic [OB-1:0] rsp_start_ff, rsp_start_in;
   logic [OB-1:0] rsp_end_ff, rsp_end_in;

   logic out_free;
   logic req_fire;
   logic is_text, is_eol, is_sot;

   // Output register takes a new item when empty or being drained.
   assign out_free     = !rsp_valid_ff || rsp_if.ready;
   // Compare stage is free when empty or moving into the output register.
   assign req_if.ready = !s1_valid_ff || out_free;
   assign req_fire     = req_if.valid && req_if.ready;
   assign is_text      = req_fire && (req_if.kind == cssm_pkg::KIND_TEXT);
   assign is_eol       = req_fire && (req_if.kind == cssm_pkg::KIND_EOL);
   assign is_sot       = req_fire && (req_if.kind == cssm_pkg::KIND_SOT);

   // ---------------- line and column counters ----------------
   logic [CB-1:0] col_ff, col_in;
   logic [LB-1:0] line_ff, line_in;

   always_comb begin
      col_in  = col_ff;
      line_in = line_ff;
      if (is_text) begin
         if (col_ff != COL_MAX) begin
            col_in = col_ff + 1'b1;
         end
      end else if (is_eol) begin
         col_in = '0;
         if (line_ff != LINE_MAX) begin
            line_in = line_ff + 1'b1;
         end
      end else if (is_sot) begin
         col_in  = '0;
         line_in = '0;
      end
   end

   // ---------------- window: row of compare cells ----------------
   // Cell k holds the folded byte k places back from the newest text byte.
   // After a text byte shifts in, the row holds the candidate match ending at
   // that byte, and cell k is compared with pattern byte len-1-k.
   cssm_pkg::cell_ctl_type cell_ctl;
   assign cell_ctl.shift = is_text;
   assign cell_ctl.clear = is_eol || is_sot;

   logic [7:0] cur_folded;
   assign cur_folded = cssm_pkg::fold(req_if.text_byte);

   logic [7:0]             chain [NC];
   logic [NC-1:0]          cell_ok;
   cssm_pkg::pat_slot_type slot [NC];

   for (genvar k = 0; k < NC; k++) begin : g_cell
      logic [LN-1:0] pidx;

      always_comb begin
         pidx = len_eff - LN'(k) - 1'b1;
         slot[k].active = (LN'(k) < len_eff);
         slot[k].value  = cssm_pkg::fold(pat_all[8*PI'(pidx) +: 8]);
      end

      if (k == 0) begin : g_head
         cssm_cell u_cell (
            .clock    (clock),
            .reset    (reset),
            .ctl      (cell_ctl),
            .byte_in  (cur_folded),
            .pat      (slot[k]),
            .byte_out (chain[k]),
            .ok       (cell_ok[k])
         );
      end else begin : g_body
         cssm_cell u_cell (
            .clock    (clock),
            .reset    (reset),
            .ctl      (cell_ctl),
            .byte_in  (chain[k-1]),
            .pat      (slot[k]),
            .byte_out (chain[k]),
            .ok       (cell_ok[k])
         );
      end
   end

   // ---------------- compare stage ----------------
   // Armed: pattern in use and the line already holds len bytes with this one.
   always_comb begin
      s1_valid_in = s1_valid_ff;
      s1_armed_in = s1_armed_ff;
      s1_col_in   = s1_col_ff;
      s1_line_in  = s1_line_ff;
      if (is_text) begin
         s1_valid_in = 1'b1;
         s1_armed_in = (len_eff != '0) && (col_ff >= CB'(len_eff - 1'b1));
         s1_col_in   = col_ff;
         s1_line_in  = line_ff;
      end else if (out_free) begin
         s1_valid_in = 1'b0;
      end
   end

   logic hit;
   assign hit = s1_valid_ff && s1_armed_ff && (&cell_ok);

   // ---------------- output register ----------------
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_line_in  = rsp_line_ff;
      rsp_start_in = rsp_start_ff;
      rsp_end_in   = rsp_end_ff;
      if (out_free) begin
         rsp_valid_in = hit;
         rsp_line_in  = OB'(s1_line_ff);
         rsp_start_in = OB'(s1_col_ff - CB'(len_eff - 1'b1));
         rsp_end_in   = OB'(s1_col_ff);
      end
   end

   assign rsp_if.valid           = rsp_valid_ff;
   assign rsp_if.match_line      = rsp_line_ff;
   assign rsp_if.match_start_col = rsp_start_ff;
   assign rsp_if.match_end_col   = rsp_end_ff;

   // ---------------- registers ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         pat_low_ff   <= '0;
         pat_high_ff  <= '0;
         pat_len_ff   <= '0;
         col_ff       <= '0;
         line_ff      <= '0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pat_low_ff   <= pat_low_in;
         pat_high_ff  <= pat_high_in;
         pat_len_ff   <= pat_len_in;
         col_ff       <= col_in;
         line_ff      <= line_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload, no reset needed
   always_ff @(posedge clock) begin
      s1_armed_ff  <= s1_armed_in;
      s1_col_ff    <= s1_col_in;
      s1_line_ff   <= s1_line_in;
      rsp_line_ff  <= rsp_line_in;
      rsp_start_ff <= rsp_start_in;
      rsp_end_ff   <= rsp_end_in;
   end

   // ---------------- assertions ----------------
`ifndef ASSERT_OFF
   a_text_loads_stage: assert property (@(posedge clock) disable iff (reset)
      is_text |=> s1_valid_ff)
      else $error("accepted text item did not reach the compare stage");

   a_eol_clears_col: assert property (@(posedge clock) disable iff (reset)
      is_eol |=> (col_ff == '0))
      else $error("end of line did not clear the column");

   a_stage_holds: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !out_free) |=> (s1_valid_ff && $stable(s1_col_ff)))
      else $error("compare stage lost an item while the output was stalled");

   a_start_le_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_start_ff <= rsp_end_ff))
      else $error("match start column beyond end column");
`endif

endmodule

FILE: sim/tb_caseless_substring_match_scanner.sv
// Self-checking testbench for the caseless substring match scanner.
module tb_caseless_substring_match_scanner;
   timeunit 1ns;
   timeprecision 1ps;

   // Unused kind code: the block must drop the item without any state change.
   localparam logic [cssm_pkg::KIND_BITS-1:0] KIND_UNUSED = 2'd3;

   localparam int RANDOM_ITEMS = 1600;
   localparam int DRAIN_CYCLES = 4;
   localparam int TAIL_CYCLES  = 10;
   localparam int TAIL_GUARD   = 20000;

   typedef struct packed {
      logic [cssm_pkg::OUT_BITS-1:0] line_no;
      logic [cssm_pkg::OUT_BITS-1:0] first_col;
      logic [cssm_pkg::OUT_BITS-1:0] last_col;
   } match_type;

   // How a directed row is checked: by the predictor, against a typed-in answer, or with no match expected.
   typedef enum logic [1:0] {CHK_MODEL, CHK_NONE, CHK_HIT} chk_type;

   typedef struct {
      logic                              is_reg;
      logic [cssm_pkg::CSR_IDX_BITS-1:0] reg_idx;
      logic [cssm_pkg::REG_BITS-1:0]     reg_data;
      logic [cssm_pkg::KIND_BITS-1:0]    kind;
      logic [7:0]                        text_val;
      chk_type                           chk;
      match_type                         typed;
   } step_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   cssm_req_if req ();
   cssm_rsp_if rsp ();
   cssm_csr_if csr ();

   caseless_substring_match_scanner dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req),
      .rsp_if (rsp),
      .csr_if (csr)
   );

   always #5 clock = ~clock;

   // ------------------------------------------------------------------
   // Predictor state: pattern registers, the line window and the counters.
   // ------------------------------------------------------------------
   logic [cssm_pkg::REG_BITS-1:0]     pat_lo, pat_hi;
   logic [cssm_pkg::LEN_REG_BITS-1:0] pat_len;
   logic [7:0]                        line_window [cssm_pkg::MAX_PATTERN];  // 0 is newest
   logic [cssm_pkg::COLUMN_BITS-1:0]  col_count;
   logic [cssm_pkg::LINE_BITS-1:0]    line_count;

   match_type    expected_matches [$];
   step_row_type directed_steps [$];
   int unsigned  fail_count = 0;

   // bit 0: sender inserts gaps, bit 1: receiver stalls
   logic [1:0] idle_sides = 2'b00;

   // Raw pattern bytes of the current random phase, used to build hits.
   logic [7:0] pat_bytes [cssm_pkg::MAX_PATTERN];

   function automatic logic [7:0] lower_ascii(input logic [7:0] b);
      if (b >= 8'h41 && b <= 8'h5A) return b | 8'h20;
      return b;
   endfunction

   // Flip the case of letters at random; other bytes pass through.
   function automatic logic [7:0] vary_case(input logic [7:0] b);
      if (((b >= 8'h41 && b <= 8'h5A) || (b >= 8'h61 && b <= 8'h7A)) && $urandom_range(0, 1))
         return b ^ 8'h20;
      return b;
   endfunction

   function automatic logic [7:0] draw_pattern_byte(input int alpha);
      int sel;
      logic [7:0] b;
      sel = $urandom_range(0, 9);
      if (sel < 5) begin
         b = vary_case(8'h61 + 8'($urandom_range(0, alpha - 1)));
      end else if (sel < 7) begin
         // bytes just outside the folded range
         case ($urandom_range(0, 3))
            0: b = 8'h40;
            1: b = 8'h5B;
            2: b = 8'h60;
            default: b = 8'h7B;
         endcase
      end else begin
         b = 8'($urandom_range(0, 255));
      end
      return b;
   endfunction

   function automatic void clear_line_state();
      foreach (line_window[i]) line_window[i] = 8'h00;
      col_count = '0;
   endfunction

   function automatic void expect_match(input match_type m);
      expected_matches.insert(expected_matches.size(), m);
   endfunction

   function automatic void add_row(input step_row_type r);
      directed_steps.insert(directed_steps.size(), r);
   endfunction

   function automatic void add_item(input logic [cssm_pkg::KIND_BITS-1:0] k,
                                    input logic [7:0] b,
                                    input chk_type chk, input match_type typed);
      step_row_type r;
      r = '{is_reg: 1'b0, reg_idx: '0, reg_data: '0, kind: k, text_val: b,
            chk: chk, typed: typed};
      add_row(r);
   endfunction

   function automatic void add_reg(input logic [cssm_pkg::CSR_IDX_BITS-1:0] idx,
                                   input logic [cssm_pkg::REG_BITS-1:0] data);
      step_row_type r;
      r = '{is_reg: 1'b1, reg_idx: idx, reg_data: data, kind: cssm_pkg::KIND_TEXT,
            text_val: '0, chk: CHK_NONE, typed: '0};
      add_row(r);
   endfunction

   // One scanner step on the predictor: update state, report a match if any.
   task automatic scan_item(input logic [cssm_pkg::KIND_BITS-1:0] k, input logic [7:0] b,
                            output logic hit, output match_type m);
      logic [7:0] cur, t, pb;
      int len, back;
      hit = 1'b0;
      m   = '0;
      case (k)
         cssm_pkg::KIND_EOL: begin
            clear_line_state();
            if (line_count != '1) line_count++;
         end
         cssm_pkg::KIND_SOT: begin
            clear_line_state();
            line_count = '0;
         end
         cssm_pkg::KIND_TEXT: begin
            cur = lower_ascii(b);
            len = (pat_len > cssm_pkg::MAX_PATTERN) ? cssm_pkg::MAX_PATTERN : int'(pat_len);
            // the line must already hold len-1 bytes before this one
            hit = (len != 0) && (int'(col_count) >= len - 1);
            for (int i = 0; i < len && hit; i++) begin
               back = len - 1 - i;
               t  = (back == 0) ? cur : line_window[back - 1];
               pb = lower_ascii((i < 8) ? pat_lo[8*i +: 8] : pat_hi[8*(i-8) +: 8]);
               if (t != pb) hit = 1'b0;
            end
            if (hit) begin
               m.line_no   = cssm_pkg::OUT_BITS'(line_count);
               m.first_col = cssm_pkg::OUT_BITS'(col_count -
                                                 cssm_pkg::COLUMN_BITS'(len - 1));
               m.last_col  = cssm_pkg::OUT_BITS'(col_count);
            end
            for (int j = cssm_pkg::MAX_PATTERN - 1; j > 0; j--)
               line_window[j] = line_window[j - 1];
            line_window[0] = cur;
            // column saturates; later bytes still shift and match
            if (col_count != '1) col_count++;
         end
         default: ;  // unused kind: no effect
      endcase
   endtask

   // ------------------------------------------------------------------
   // Channel drivers
   // ------------------------------------------------------------------

   // Send one item and, once accepted, record what it should produce.
   task automatic send_item(input logic [cssm_pkg::KIND_BITS-1:0] k, input logic [7:0] b,
                            input chk_type chk, input match_type typed);
      int gap;
      logic hit;
      match_type m;
      gap = idle_sides[0] ? int'($urandom_range(0, 12)) : 0;
      if (gap > 0) begin
         req.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req.valid     <= 1'b1;
      req.kind      <= k;
      req.text_byte <= b;
      do @(posedge clock); while (!req.ready);
      scan_item(k, b, hit, m);
      if (chk == CHK_HIT) expect_match(typed);
      else if (chk == CHK_MODEL && hit) expect_match(m);
   endtask

   // Hold off the sender until every expected match has arrived, plus pipeline slack.
   task automatic wait_for_matches();
      req.valid <= 1'b0;
      while (expected_matches.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Register writes only happen with the scanner idle.
   task automatic write_reg(input logic [cssm_pkg::CSR_IDX_BITS-1:0] idx,
                            input logic [cssm_pkg::REG_BITS-1:0] data);
      wait_for_matches();
      csr.valid <= 1'b1;
      csr.index <= idx;
      csr.data  <= data;
      do @(posedge clock); while (!csr.ready);
      csr.valid <= 1'b0;
      case (idx)
         cssm_pkg::REG_PAT_LOW:  pat_lo  = data;
         cssm_pkg::REG_PAT_HIGH: pat_hi  = data;
         cssm_pkg::REG_PAT_LEN:  pat_len = data[cssm_pkg::LEN_REG_BITS-1:0];
         default: ;
      endcase
   endtask

   // ------------------------------------------------------------------
   // Receiver: random stall before each match item.
   // ------------------------------------------------------------------
   initial begin : rsp_pacing
      int stall;
      rsp.ready <= 1'b0;
      while (reset) @(posedge clock);
      forever begin
         stall = idle_sides[1] ? int'($urandom_range(0, 12)) : 0;
         if (stall > 0) begin
            rsp.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp.ready <= 1'b1;
         do @(posedge clock); while (!rsp.valid);
      end
   end

   // ------------------------------------------------------------------
   // Match checker: each accepted match item against the oldest expectation.
   // ------------------------------------------------------------------
   always @(posedge clock) begin : match_check
      match_type want;
      if (!reset && rsp.valid && rsp.ready) begin
         if (expected_matches.size() == 0) begin
            fail_count++;
            if (fail_count <= 10)
               $display("unexpected match item: line %0d cols %0d..%0d",
                        rsp.match_line, rsp.match_start_col, rsp.match_end_col);
         end else begin
            want = expected_matches.pop_front();
            if (want.line_no !== rsp.match_line || want.first_col !== rsp.match_start_col ||
                want.last_col !== rsp.match_end_col) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("match mismatch: expected line %0d cols %0d..%0d, got %0d %0d..%0d",
                           want.line_no, want.first_col, want.last_col,
                           rsp.match_line, rsp.match_start_col, rsp.match_end_col);
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // Stimulus
   // ------------------------------------------------------------------
   initial begin : stimulus
      int phase, target, n, sel, eff, ci, alpha, len_pick, text_items, guard;
      logic [7:0] b;
      logic [cssm_pkg::REG_BITS-1:0] lo, hi, len_word;

      pat_lo     = '0;
      pat_hi     = '0;
      pat_len    = '0;
      line_count = '0;
      clear_line_state();

      req.valid     <= 1'b0;
      req.kind      <= cssm_pkg::KIND_TEXT;
      req.text_byte <= 8'h00;
      csr.valid     <= 1'b0;
      csr.index     <= cssm_pkg::REG_PAT_LOW;
      csr.data      <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // --- directed part -----------------------------------------------
      // Zero pattern length straight out of reset: nothing may match.
      add_item(cssm_pkg::KIND_TEXT, 8'h41, CHK_NONE, '0);
      add_reg(cssm_pkg::REG_PAT_LOW, 64'h4261);                  // "aB" folds to "ab"
      add_reg(cssm_pkg::REG_PAT_LEN, 64'd2);
      add_item(cssm_pkg::KIND_TEXT, 8'h41, CHK_NONE, '0);        // col 1
      add_item(cssm_pkg::KIND_TEXT, 8'h62, CHK_HIT, '{16'd0, 16'd1, 16'd2});
      add_item(cssm_pkg::KIND_TEXT, 8'h61, CHK_NONE, '0);
      add_item(cssm_pkg::KIND_TEXT, 8'h42, CHK_HIT, '{16'd0, 16'd3, 16'd4});
      add_item(KIND_UNUSED, 8'h61, CHK_NONE, '0);                // dropped, column stays
      add_item(cssm_pkg::KIND_TEXT, 8'h40, CHK_MODEL, '0);
      add_item(cssm_pkg::KIND_EOL, 8'hFF, CHK_NONE, '0);
      add_item(cssm_pkg::KIND_TEXT, 8'h61, CHK_NONE, '0);        // line 1, fresh window
      add_item(cssm_pkg::KIND_TEXT, 8'h62, CHK_HIT, '{16'd1, 16'd0, 16'd1});
      add_item(cssm_pkg::KIND_TEXT, 8'h61, CHK_MODEL, '0);
      add_item(cssm_pkg::KIND_SOT, 8'h00, CHK_NONE, '0);
      // after start of text the stale 'a' must be gone
      add_item(cssm_pkg::KIND_TEXT, 8'h62, CHK_NONE, '0);
      add_reg(cssm_pkg::REG_PAT_LOW, 64'h7A5A);                  // "Zz"
      add_item(cssm_pkg::KIND_TEXT, 8'h40, CHK_MODEL, '0);
      add_item(cssm_pkg::KIND_TEXT, 8'h7A, CHK_MODEL, '0);
      add_item(cssm_pkg::KIND_TEXT, 8'h5A, CHK_MODEL, '0);
      add_item(cssm_pkg::KIND_TEXT, 8'h5B, CHK_MODEL, '0);
      add_item(cssm_pkg::KIND_TEXT, 8'h60, CHK_MODEL, '0);
      add_item(cssm_pkg::KIND_TEXT, 8'h7B, CHK_MODEL, '0);
      add_reg(cssm_pkg::REG_PAT_HIGH, '1);
      add_reg(cssm_pkg::REG_PAT_LOW, 64'hFF);
      add_reg(cssm_pkg::REG_PAT_LEN, 64'd1);
      add_item(cssm_pkg::KIND_TEXT, 8'hFF, CHK_HIT, '{16'd0, 16'd7, 16'd7});
      add_item(cssm_pkg::KIND_TEXT, 8'h00, CHK_MODEL, '0);
      add_reg(cssm_pkg::REG_PAT_LEN, 64'd0);
      add_item(cssm_pkg::KIND_TEXT, 8'hFF, CHK_NONE, '0);

      idle_sides = 2'b11;
      foreach (directed_steps[i]) begin
         if (directed_steps[i].is_reg)
            write_reg(directed_steps[i].reg_idx, directed_steps[i].reg_data);
         else
            send_item(directed_steps[i].kind, directed_steps[i].text_val,
                      directed_steps[i].chk, directed_steps[i].typed);
      end

      // --- random part --------------------------------------------------
      // Each phase: new pattern (sent only while idle), then text that mostly
      // embeds case-varied copies of the pattern, sprinkled with line marks.
      send_item(cssm_pkg::KIND_SOT, 8'h00, CHK_MODEL, '0);
      phase = 0;
      text_items = 0;
      while (text_items < RANDOM_ITEMS) begin
         alpha = ($urandom_range(0, 2) == 0) ? 2 : 26;   // tiny alphabet -> overlaps
         case (phase)
            0: len_pick = cssm_pkg::MAX_PATTERN;
            1: len_pick = 31;                              // clamps to the maximum
            2: len_pick = 0;
            3: len_pick = 3;                               // all-zero pattern
            default: begin
               sel = $urandom_range(0, 19);
               if (sel == 0) len_pick = 0;
               else if (sel <= 2) len_pick = 1;
               else if (sel <= 10) len_pick = $urandom_range(2, 4);
               else if (sel <= 14) len_pick = $urandom_range(5, 8);
               else if (sel <= 16) len_pick = cssm_pkg::MAX_PATTERN;
               else if (sel == 17) len_pick = $urandom_range(cssm_pkg::MAX_PATTERN + 1, 31);
               else len_pick = $urandom_range(9, cssm_pkg::MAX_PATTERN - 1);
            end
         endcase
         for (int i = 0; i < cssm_pkg::MAX_PATTERN; i++) begin
            if (phase == 3) pat_bytes[i] = 8'h00;
            else if (i < len_pick) pat_bytes[i] = draw_pattern_byte(alpha);
            else pat_bytes[i] = 8'($urandom_range(0, 255));   // unused, still toggled
         end
         for (int i = 0; i < 8; i++) begin
            lo[8*i +: 8] = pat_bytes[i];
            hi[8*i +: 8] = pat_bytes[i + 8];
         end
         len_word = {$urandom(), $urandom()};              // upper bits are don't-care
         len_word[cssm_pkg::LEN_REG_BITS-1:0] = cssm_pkg::LEN_REG_BITS'(len_pick);
         write_reg(cssm_pkg::REG_PAT_LOW, lo);
         write_reg(cssm_pkg::REG_PAT_HIGH, hi);
         write_reg(cssm_pkg::REG_PAT_LEN, len_word);

         eff = (len_pick > cssm_pkg::MAX_PATTERN) ? cssm_pkg::MAX_PATTERN : len_pick;
         idle_sides = 2'($urandom_range(0, 3));
         target = $urandom_range(90, 170);
         n = 0;
         while (n < target) begin
            sel = $urandom_range(0, 99);
            if (sel < 3) begin
               send_item(cssm_pkg::KIND_EOL, 8'($urandom_range(0, 255)), CHK_MODEL, '0);
               n++;
            end else if (sel == 3) begin
               send_item(cssm_pkg::KIND_SOT, 8'($urandom_range(0, 255)), CHK_MODEL, '0);
               n++;
            end else if (sel == 4) begin
               send_item(KIND_UNUSED, 8'($urandom_range(0, 255)), CHK_MODEL, '0);
            end else if (sel < 45) begin
               // full occurrence, now and then with one byte broken
               ci = -1;
               if ($urandom_range(0, 4) == 0)
                  ci = int'($urandom_range(0, cssm_pkg::MAX_PATTERN - 1));
               for (int i = 0; i < eff; i++) begin
                  b = (i == ci) ? 8'($urandom_range(0, 255)) : vary_case(pat_bytes[i]);
                  send_item(cssm_pkg::KIND_TEXT, b, CHK_MODEL, '0);
                  n++;
               end
               if (eff == 0) begin
                  send_item(cssm_pkg::KIND_TEXT, vary_case(pat_bytes[0]), CHK_MODEL, '0);
                  n++;
               end
            end else if (sel < 80) begin
               b = vary_case(pat_bytes[$urandom_range(0, (eff > 0) ? eff - 1 : 0)]);
               send_item(cssm_pkg::KIND_TEXT, b, CHK_MODEL, '0);
               n++;
            end else begin
               send_item(cssm_pkg::KIND_TEXT, 8'($urandom_range(0, 255)), CHK_MODEL, '0);
               n++;
            end
         end
         text_items += n;
         phase++;
      end

      // --- wind down ----------------------------------------------------
      req.valid <= 1'b0;
      guard = 0;
      while (expected_matches.size() != 0 && guard < TAIL_GUARD) begin
         @(posedge clock);
         guard++;
      end
      repeat (TAIL_CYCLES) @(posedge clock);
      if (expected_matches.size() != 0) begin
         fail_count++;
         if (fail_count <= 10)
            $display("%0d expected match items never arrived", expected_matches.size());
      end

      if (fail_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

   // Hard stop well beyond the slowest legal run.
   initial begin : watchdog
      #8ms;
      $display("DONE: errors detected");
      $finish;
   end

endmodule
